>>> rtl/lkv_pkg.sv
// shared constants and types for the lru key/value cache
package lkv_pkg;

    localparam int N_ENTRIES = 16;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CAP_W     = 5;
    localparam int IDX_W     = $clog2(N_ENTRIES + 1);
    localparam int CMP_W     = (CAP_W > IDX_W) ? CAP_W : IDX_W;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // register index of the capacity register
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

    // command codes carried in tuser
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // one stored entry
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    // per cell control from the sequencer
    typedef struct packed {
        logic cmp;    // compare stored key against the broadcast key
        logic shift;  // take the neighbor's entry
        logic evict;  // drop the entry after the shift
    } t_cell_ctl;

endpackage

>>> rtl/lkv_cell.sv
// one recency-ordered cache cell: holds an entry, compares and shifts from its neighbor
module lkv_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lkv_pkg::t_cell_ctl           i_ctl,
    input  logic [lkv_pkg::KEY_W-1:0]    i_key,
    input  lkv_pkg::t_entry              i_nb,
    output lkv_pkg::t_entry              o_entry,
    output logic                         o_match
);

    logic                      r_valid;
    logic [lkv_pkg::KEY_W-1:0] r_key;
    logic [lkv_pkg::VAL_W-1:0] r_value;
    logic                      r_match;
    logic                      n_valid;

    // valid follows the shift, then eviction clears it
    always_comb begin
        n_valid = i_ctl.shift ? i_nb.valid : r_valid;
        if (i_ctl.evict) begin
            n_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctl.cmp) begin
                r_match <= r_valid && (r_key == i_key);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key   <= i_nb.key;
            r_value <= i_nb.value;
        end
    end

    assign o_entry.valid = r_valid;
    assign o_entry.key   = r_key;
    assign o_entry.value = r_value;
    assign o_match       = r_match;

endmodule

>>> rtl/lru_key_value_cache.sv
// lru key/value cache: a chain of cells ordered by recency, head cell most recent
// an accepted item goes through a key compare step, then an update step that loads the result
// items are taken one at a time: the input is ready only in idle, after compare and update
// a result waiting in the output register holds the next item in update and the input off
// reset: synchronous active low, clears all valid bits, capacity returns to 16
// no clearing pass after reset: the first item is accepted in the next cycle
module lru_key_value_cache (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0] s_axis_tdata,  // key, put_value
    input  logic                          s_axis_tuser,  // command
    // result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lkv_pkg::VAL_W-1:0]     m_axis_tdata,  // read_value
    output logic                          m_axis_tuser,  // hit
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkv_pkg::APB_AW-1:0]    paddr,
    input  logic [lkv_pkg::APB_DW-1:0]    pwdata,
    output logic [lkv_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int N = lkv_pkg::N_ENTRIES;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} t_state;

    t_state                          r_state;
    logic                            r_cmd;
    logic [lkv_pkg::KEY_W-1:0]       r_key;
    logic [lkv_pkg::VAL_W-1:0]       r_val;
    logic                            r_out_valid;
    logic                            r_out_hit;
    logic [lkv_pkg::VAL_W-1:0]       r_out_data;
    logic [lkv_pkg::CAP_W-1:0]       r_capacity;

    lkv_pkg::t_entry                 w_entry [N];
    lkv_pkg::t_entry                 w_nb    [N];
    lkv_pkg::t_cell_ctl              w_ctl   [N];
    logic [N-1:0]                    w_match;
    logic [N-1:0]                    w_valid;
    logic [N-1:0]                    w_upto_hit;
    logic                            w_hit;
    logic [lkv_pkg::VAL_W-1:0]       w_hit_value;
    logic [lkv_pkg::CMP_W-1:0]       w_cap;
    logic                            w_commit;
    lkv_pkg::t_entry                 w_front;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == lkv_pkg::REG_CAPACITY)
                  ? lkv_pkg::APB_DW'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkv_pkg::CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == lkv_pkg::REG_CAPACITY) begin
            r_capacity <= pwdata[lkv_pkg::CAP_W-1:0];
        end
    end

    // capacity clamped to the number of cells
    assign w_cap = (lkv_pkg::CMP_W'(r_capacity) > lkv_pkg::CMP_W'(N))
                 ? lkv_pkg::CMP_W'(N) : lkv_pkg::CMP_W'(r_capacity);

    // hit detect, hit value select and the run of cells at or before the hit
    always_comb begin
        logic acc;
        w_hit       = 1'b0;
        w_hit_value = '0;
        for (int i = 0; i < N; i++) begin
            w_hit       = w_hit | w_match[i];
            w_hit_value = w_hit_value | ({lkv_pkg::VAL_W{w_match[i]}} & w_entry[i].value);
        end
        acc = 1'b0;
        for (int i = N - 1; i >= 0; i--) begin
            acc           = acc | w_match[i];
            w_upto_hit[i] = acc;
        end
    end

    // update happens once the output register can take the result
    assign w_commit = (r_state == S_UPD) && (!r_out_valid || m_axis_tready);

    // entry entering the head cell
    assign w_front.valid = 1'b1;
    assign w_front.key   = r_key;
    assign w_front.value = (r_cmd == lkv_pkg::CMD_PUT) ? r_val : w_hit_value;

    // cell chain
    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_nb[g] = w_front;
        end else begin : g_body
            assign w_nb[g] = w_entry[g-1];
        end

        assign w_ctl[g].cmp   = (r_state == S_CMP);
        assign w_ctl[g].shift = w_commit && (w_hit ? w_upto_hit[g]
                                                   : (r_cmd == lkv_pkg::CMD_PUT));
        assign w_ctl[g].evict = w_commit && !w_hit && (r_cmd == lkv_pkg::CMD_PUT)
                                && (lkv_pkg::CMP_W'(g) >= w_cap);

        lkv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_key   (r_key),
            .i_nb    (w_nb[g]),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );

        assign w_valid[g] = w_entry[g].valid;
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // result held until taken, a new one loads as the update commits
            r_out_valid <= w_commit || (r_out_valid && !m_axis_tready);
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= s_axis_tuser;
            r_key <= s_axis_tdata[lkv_pkg::KEY_W-1:0];
            r_val <= s_axis_tdata[lkv_pkg::KEY_W +: lkv_pkg::VAL_W];
        end
        if (w_commit) begin
            r_out_hit <= w_hit;
            if (r_cmd == lkv_pkg::CMD_PUT) begin
                r_out_data <= '0;
            end else if (w_hit) begin
                r_out_data <= w_hit_value;
            end else begin
                r_out_data <= '1;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_hit;

    // a key sits in at most one cell
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("key matched in more than one cell");

    // valid cells form an unbroken run from the head
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("gap in the valid run of the cell chain");

    // a result appears only out of the update step
    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_commit))
        else $error("result raised without an update");

    // a put with nonzero capacity leaves its entry in the head cell
    a_put_lands_at_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_cmd == lkv_pkg::CMD_PUT && w_cap != '0) |=>
            (w_entry[0].valid && w_entry[0].key == $past(r_key)))
        else $error("put entry missing from the head cell");

endmodule

>>> tb/sv/tb_lru_key_value_cache.sv
// self-checking testbench for the lru key/value cache: stream items, apb capacity writes
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

    localparam int RESULT_LIMIT_NS = 400000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam logic [lkv_pkg::APB_AW-1:0] CAPACITY_ADDR = {lkv_pkg::REG_CAPACITY, 2'b00};
    localparam logic [lkv_pkg::APB_AW-1:0] UNUSED_ADDR   = {~lkv_pkg::REG_CAPACITY, 2'b00};

    // one cache access as offered to the block
    typedef struct packed {
        logic                      cmd;
        logic [lkv_pkg::KEY_W-1:0] key;
        logic [lkv_pkg::VAL_W-1:0] value;
    } t_cache_op;

    // one lookup result
    typedef struct packed {
        logic                      hit;
        logic [lkv_pkg::VAL_W-1:0] value;
    } t_lookup;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                                      s_axis_tvalid = 1'b0;
    logic                                      s_axis_tready;
    logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0]  s_axis_tdata  = '0;  // key, put_value
    logic                                      s_axis_tuser  = lkv_pkg::CMD_GET;  // command
    logic                                      m_axis_tvalid;
    logic                                      m_axis_tready = 1'b0;
    logic [lkv_pkg::VAL_W-1:0]                 m_axis_tdata;  // read_value
    logic                                      m_axis_tuser;  // hit

    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [lkv_pkg::APB_AW-1:0]    paddr   = '0;
    logic [lkv_pkg::APB_DW-1:0]    pwdata  = '0;
    logic [lkv_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    lru_key_value_cache DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow copy of the cache contents and recency order
    logic [lkv_pkg::KEY_W-1:0] shadow_key  [lkv_pkg::N_ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] shadow_val  [lkv_pkg::N_ENTRIES];
    bit                        shadow_used [lkv_pkg::N_ENTRIES];
    int unsigned               shadow_age  [lkv_pkg::N_ENTRIES];
    logic [lkv_pkg::CAP_W-1:0] shadow_cap;

    t_cache_op pending_ops[$];
    t_lookup   expected_lookups[$];
    logic [lkv_pkg::KEY_W-1:0] key_pool[32];

    int  mismatches  = 0;
    bit  input_taken = 1'b0;
    bit  no_idle     = 1'b0;
    bit  hold_go     = 1'b0;
    bit  long_hold   = 1'b0;
    int  send_gap    = 0;
    int  recv_gap    = 0;

    // apply one access to the shadow cache and work out its result
    function automatic t_lookup cache_access(input t_cache_op op);
        t_lookup res;
        int s;
        int lim;
        int unsigned r;
        s = -1;
        for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
            if (s < 0 && shadow_used[i] && shadow_key[i] == op.key) s = i;
        end
        res.hit = (s >= 0);
        res.value = '0;
        if (s >= 0) begin
            if (op.cmd == lkv_pkg::CMD_GET) res.value = shadow_val[s];
            else shadow_val[s] = op.value;
            // promote: more recent entries age by one
            r = shadow_age[s];
            for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
                if (shadow_used[i] && shadow_age[i] < r) shadow_age[i]++;
            end
            shadow_age[s] = 0;
        end else if (op.cmd == lkv_pkg::CMD_GET) begin
            res.value = '1;
        end else begin
            lim = (shadow_cap > lkv_pkg::N_ENTRIES) ? lkv_pkg::N_ENTRIES : int'(shadow_cap);
            for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
                if (s < 0 && !shadow_used[i]) s = i;
            end
            // no free slot: reuse the least recent one
            if (s < 0) begin
                s = 0;
                for (int i = 1; i < lkv_pkg::N_ENTRIES; i++) begin
                    if (shadow_age[i] > shadow_age[s]) s = i;
                end
                shadow_used[s] = 1'b0;
            end
            for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
                if (shadow_used[i]) shadow_age[i]++;
            end
            shadow_key[s]  = op.key;
            shadow_val[s]  = op.value;
            shadow_used[s] = 1'b1;
            shadow_age[s]  = 0;
            // drop everything ranked at or beyond the capacity
            for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
                if (shadow_used[i] && shadow_age[i] >= lim) shadow_used[i] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic [lkv_pkg::KEY_W-1:0] pick_key(input int pool_n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return key_pool[$urandom_range(0, pool_n - 1)];
        if (r < 90) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0s: expected %h, got %h at %0t", what, want, got, $realtime);
    endtask

    task automatic push_op(input logic cmd, input logic [lkv_pkg::KEY_W-1:0] key,
                           input logic [lkv_pkg::VAL_W-1:0] value);
        t_cache_op op;
        op.cmd = cmd;
        op.key = key;
        op.value = value;
        pending_ops.push_back(op);
    endtask

    task automatic fill_pool();
        for (int i = 0; i < 32; i++) key_pool[i] = $urandom;
    endtask

    task automatic add_random(input int n, input int pool_n, input int put_pct);
        for (int i = 0; i < n; i++)
            push_op(($urandom_range(0, 99) < put_pct) ? lkv_pkg::CMD_PUT : lkv_pkg::CMD_GET,
                    pick_key(pool_n), $urandom);
    endtask

    // wait until every item is sent and every result has come back
    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_axis_tvalid || expected_lookups.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write, then read the capacity register back
    task automatic apb_write(input logic [lkv_pkg::APB_AW-1:0] addr,
                             input logic [lkv_pkg::APB_DW-1:0] data);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[lkv_pkg::APB_AW-1:2] == lkv_pkg::REG_CAPACITY)
            shadow_cap = data[lkv_pkg::CAP_W-1:0];
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = CAPACITY_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== lkv_pkg::APB_DW'(shadow_cap))
            report_mismatch("capacity readback", 64'(shadow_cap), 64'(prdata));
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #RESULT_LIMIT_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // long receiver hold so that the block backs up and stalls its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // input driver
    always @(negedge i_clk) begin
        t_cache_op op;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !input_taken) begin
            // hold the item until accepted
        end else if (send_gap > 0) begin
            send_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0 && !no_idle && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 4) - 1;
            s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
            op = pending_ops.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {op.value, op.key};
            s_axis_tuser  <= op.cmd;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n || long_hold) begin
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(1, 4) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // check results, then predict for the item accepted at this edge
    always @(posedge i_clk) begin
        t_lookup got;
        t_lookup want;
        t_cache_op op;
        if (!i_rst_n) begin
            input_taken = 1'b0;
        end else begin
            input_taken = s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit = m_axis_tuser;
                got.value = m_axis_tdata;
                if (expected_lookups.size() == 0) begin
                    report_mismatch("unexpected result", '0, 64'(got));
                end else begin
                    want = expected_lookups.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 64'(want.hit), 64'(got.hit));
                    if (got.value !== want.value)
                        report_mismatch("read_value", 64'(want.value), 64'(got.value));
                end
            end
            if (input_taken) begin
                op.cmd = s_axis_tuser;
                op.key = s_axis_tdata[lkv_pkg::KEY_W-1:0];
                op.value = s_axis_tdata[lkv_pkg::KEY_W +: lkv_pkg::VAL_W];
                expected_lookups.push_back(cache_access(op));
            end
        end
    end

    // stimulus
    initial begin
        for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
            shadow_key[i] = '0;
            shadow_val[i] = '0;
            shadow_used[i] = 1'b0;
            shadow_age[i] = 0;
        end
        shadow_cap = lkv_pkg::CAPACITY_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes of keys and values, hits, misses, update
        @(posedge i_clk);
        push_op(lkv_pkg::CMD_GET, 32'h0000_0000, 32'h5555_5555);
        push_op(lkv_pkg::CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
        push_op(lkv_pkg::CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
        push_op(lkv_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        push_op(lkv_pkg::CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
        push_op(lkv_pkg::CMD_GET, 32'h8000_0000, 32'hffff_ffff);
        push_op(lkv_pkg::CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
        push_op(lkv_pkg::CMD_GET, 32'h0000_0000, 32'haaaa_aaaa);
        push_op(lkv_pkg::CMD_GET, 32'hffff_ffff, 32'h0000_0000);
        push_op(lkv_pkg::CMD_PUT, 32'hffff_ffff, 32'h1234_5678);
        push_op(lkv_pkg::CMD_GET, 32'hffff_ffff, 32'h0000_0000);
        push_op(lkv_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000);
        push_op(lkv_pkg::CMD_PUT, 32'h0000_0000, 32'hdead_beef);
        push_op(lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // full capacity, pool larger than the cache
        fill_pool();
        @(posedge i_clk);
        add_random(200, 24, 50);
        wait_drained();

        // fill, then lower the capacity below the entry count
        fill_pool();
        @(posedge i_clk);
        for (int i = 0; i < lkv_pkg::N_ENTRIES; i++)
            push_op(lkv_pkg::CMD_PUT, key_pool[i], $urandom);
        wait_drained();
        apb_write(CAPACITY_ADDR, {$urandom} & ~32'h1f | 32'd3);
        @(posedge i_clk);
        for (int i = 0; i < lkv_pkg::N_ENTRIES; i++)
            push_op(lkv_pkg::CMD_GET, key_pool[i], $urandom);
        push_op(lkv_pkg::CMD_PUT, $urandom, $urandom);
        for (int i = 0; i < lkv_pkg::N_ENTRIES; i++)
            push_op(lkv_pkg::CMD_GET, key_pool[i], $urandom);
        wait_drained();

        // capacity one
        apb_write(CAPACITY_ADDR, 32'd1);
        fill_pool();
        @(posedge i_clk);
        add_random(150, 4, 50);
        wait_drained();

        // capacity zero: nothing is ever kept
        apb_write(CAPACITY_ADDR, 32'd0);
        @(posedge i_clk);
        add_random(100, 4, 50);
        wait_drained();

        // capacity above the entry count, with a long receiver stall
        apb_write(CAPACITY_ADDR, 32'd31);
        fill_pool();
        @(posedge i_clk);
        hold_go = 1'b1;
        add_random(200, 24, 50);
        wait_drained();

        // capacity two
        apb_write(CAPACITY_ADDR, 32'd2);
        fill_pool();
        @(posedge i_clk);
        add_random(150, 6, 40);
        wait_drained();

        // random capacity
        apb_write(CAPACITY_ADDR, $urandom);
        fill_pool();
        @(posedge i_clk);
        add_random(200, 20, 50);
        wait_drained();

        // write to an unused register is ignored, then a run with no idling
        apb_write(UNUSED_ADDR, 32'd4);
        apb_write(CAPACITY_ADDR, 32'd16);
        apb_write(UNUSED_ADDR, $urandom);
        fill_pool();
        @(posedge i_clk);
        no_idle = 1'b1;
        add_random(200, 12, 50);
        wait_drained();

        if (mismatches == 0 && expected_lookups.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> lru_key_value_cache.f
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache.sv
tb/sv/tb_lru_key_value_cache.sv
